// File: hw/rtl/salc_pkg.sv
// Package: shared types, constants and helpers for the LRU cache hit model.
`timescale 1ns / 1ps
package salc_pkg;

  localparam int unsigned DefCacheBytes = 16384;
  localparam int unsigned DefMaxWays    = 16;
  localparam int unsigned LineBytes     = 32;
  localparam int unsigned OffsetBits    = 5;
  localparam int unsigned AddrW         = 32;
  localparam int unsigned CntW          = 32;
  localparam int unsigned RankW         = 4;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 3;
  localparam int unsigned WlW           = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WAYS_LOG2 = 2'd0,
    REG_MODE      = 2'd1
  } salc_reg_e;

  typedef enum logic [1:0] {
    MODE_PLAIN     = 2'd0,
    MODE_NO_ST_ALC = 2'd1,
    MODE_PF_ALWAYS = 2'd2,
    MODE_PF_MISS   = 2'd3
  } salc_mode_e;

  typedef struct packed {
    logic [AddrW-1:0] address;
    logic             is_store;
  } salc_in_t;

  typedef struct packed {
    logic            hit;
    logic [CntW-1:0] hit_total;
    logic [CntW-1:0] access_total;
  } salc_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // take a new item
    logic rd;         // read the set's row
    logic upd;        // look up and write back the row
    logic pf;         // current lookup is the prefetch
    logic adv_line;   // advance the lookup address by one line
    logic out_load;   // move result into the output register
  } salc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_pf;
    logic out_busy;
  } salc_sts_t;

  // Clamp a written associativity to 1..max_wl.
  function automatic logic [WlW-1:0] clamp_wl(logic [WlW-1:0] v, logic [WlW-1:0] max_wl);
    logic [WlW-1:0] r;
    r = v;
    if (r < WlW'(1)) r = WlW'(1);
    if (r > max_wl) r = max_wl;
    return r;
  endfunction

  function automatic logic [CntW-1:0] sat_inc(logic [CntW-1:0] v);
    return (&v) ? v : v + CntW'(1);
  endfunction

endpackage

// File: hw/rtl/salc_ctrl.sv
// Sequencer: steps each item through demand and optional prefetch lookups.
`timescale 1ns / 1ps
module salc_ctrl
  import salc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  salc_sts_t sts_i,
  output salc_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_READ   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_DONE   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   pf_q, pf_d;

  always_comb begin
    state_d = state_q;
    pf_d    = pf_q;
    cmd_o   = '0;
    cmd_o.pf = pf_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          pf_d       = 1'b0;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.upd = 1'b1;
        if (!pf_q && sts_i.need_pf) begin
          cmd_o.adv_line = 1'b1;
          pf_d           = 1'b1;
          state_d        = ST_READ;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pf_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pf_q    <= pf_d;
    end
  end

endmodule

// File: hw/rtl/salc_dp.sv
// Datapath: set memory, tag compare, LRU update, counters and output register.
`timescale 1ns / 1ps
module salc_dp
  import salc_pkg::*;
#(
  parameter int unsigned CacheBytes = DefCacheBytes,
  parameter int unsigned MaxWays    = DefMaxWays
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  salc_in_t            in_data_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  salc_cmd_t           cmd_i,
  output salc_sts_t           sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output salc_out_t           out_data_o
);

  localparam int unsigned NumLines  = CacheBytes / LineBytes;
  localparam int unsigned LinesLog2 = $clog2(NumLines);
  localparam int unsigned MwLog2Raw = $clog2(MaxWays);
  localparam int unsigned MwLog2    = (MwLog2Raw > 4) ? 4 : MwLog2Raw;
  localparam int unsigned Lanes     = 1 << MwLog2;
  localparam int unsigned Rows      = NumLines / Lanes;
  localparam int unsigned RowW      = LinesLog2 - MwLog2;
  localparam int unsigned TagW      = AddrW - OffsetBits - RowW;
  localparam int unsigned LaneW     = TagW + RankW + 1;
  localparam int unsigned RowBits   = Lanes * LaneW;
  localparam int unsigned WaysW     = RankW + 1;

  // configuration
  logic [WlW-1:0] wl_q;
  salc_mode_e     mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q   <= WlW'(1);
      mode_q <= MODE_PLAIN;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WAYS_LOG2: wl_q <= clamp_wl(cfg_data_i, WlW'(MwLog2));
        REG_MODE:      mode_q <= salc_mode_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  logic flush;
  assign flush = cfg_we_i && (cfg_index_i == REG_WAYS_LOG2);

  // lookup address
  logic [AddrW-1:0] addr_q;
  logic             store_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q  <= in_data_i.address;
      store_q <= in_data_i.is_store;
    end else if (cmd_i.adv_line) begin
      addr_q <= addr_q + AddrW'(LineBytes);
    end
  end

  // geometry
  logic [WaysW-1:0]     ways;
  logic [LinesLog2-1:0] set_idx, line_pos;
  logic [AddrW-1:0]     tag_full;
  logic [TagW-1:0]      tag;
  logic [RowW-1:0]      row;
  logic [MwLog2-1:0]    base_lane;

  always_comb begin
    ways      = WaysW'(1) << wl_q;
    set_idx   = addr_q[OffsetBits +: LinesLog2] & ({LinesLog2{1'b1}} >> wl_q);
    line_pos  = set_idx << wl_q;
    tag_full  = addr_q >> (OffsetBits + LinesLog2 - 32'(wl_q));
    tag       = tag_full[TagW-1:0];
    row       = line_pos[LinesLog2-1 -: RowW];
    base_lane = line_pos[MwLog2-1:0];
  end

  // set memory, one row holds Lanes ways; row valid flags clear on reset and flush
  logic [RowBits-1:0] mem [Rows];
  logic [RowBits-1:0] rdata_q, wdata;
  logic [Rows-1:0]    row_vld_q;
  logic               rvld_q;
  logic               do_write;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rdata_q <= mem[row];
    end
    if (cmd_i.upd && do_write) begin
      mem[row] <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rvld_q    <= 1'b0;
    end else begin
      if (cmd_i.rd) rvld_q <= row_vld_q[row];
      if (flush) begin
        row_vld_q <= '0;
      end else if (cmd_i.upd && do_write) begin
        row_vld_q[row] <= 1'b1;
      end
    end
  end

  // compare, victim choice and rank update
  logic [Lanes-1:0]             v, in_set;
  logic [Lanes-1:0][RankW-1:0]  rk;
  logic [Lanes-1:0][TagW-1:0]   tg;
  logic                         hit_any, free_any, alloc;
  logic [MwLog2-1:0]            hit_lane, free_lane, old_lane, tgt;
  logic [WaysW-1:0]             old_rank;
  logic [RankW-1:0]             nrk;
  logic                         nv;
  logic [TagW-1:0]              ntg;

  always_comb begin
    hit_any   = 1'b0;
    free_any  = 1'b0;
    hit_lane  = base_lane;
    free_lane = base_lane;
    old_lane  = base_lane;
    for (int j = Lanes - 1; j >= 0; j--) begin
      v[j]  = rvld_q & rdata_q[j*LaneW + LaneW - 1];
      rk[j] = rvld_q ? rdata_q[j*LaneW + TagW +: RankW] : '0;
      tg[j] = rdata_q[j*LaneW +: TagW];
      in_set[j] = ((MwLog2'(j) ^ base_lane) >> wl_q) == '0;
      if (in_set[j] && v[j] && tg[j] == tag) begin
        hit_any  = 1'b1;
        hit_lane = MwLog2'(j);
      end
      if (in_set[j] && !v[j]) begin
        free_any  = 1'b1;
        free_lane = MwLog2'(j);
      end
      // ranks of a full set are a permutation, so the oldest is unique
      if (in_set[j] && {1'b0, rk[j]} == ways - WaysW'(1)) begin
        old_lane = MwLog2'(j);
      end
    end
    alloc    = cmd_i.pf || !(mode_q == MODE_NO_ST_ALC && store_q);
    do_write = hit_any || alloc;
    tgt      = hit_any ? hit_lane : (free_any ? free_lane : old_lane);
    old_rank = v[tgt] ? {1'b0, rk[tgt]} : ways;
    wdata    = '0;
    for (int j = 0; j < Lanes; j++) begin
      nv  = v[j];
      nrk = rk[j];
      ntg = tg[j];
      if (MwLog2'(j) == tgt) begin
        nrk = '0;
        if (!hit_any) begin
          ntg = tag;
          nv  = 1'b1;
        end
      end else if (in_set[j] && v[j] && {1'b0, rk[j]} < old_rank) begin
        nrk = rk[j] + RankW'(1);
      end
      wdata[j*LaneW +: LaneW] = {nv, nrk, ntg};
    end
  end

  assign sts_o.need_pf = (mode_q == MODE_PF_ALWAYS) ||
                         (mode_q == MODE_PF_MISS && !hit_any);

  // counters and demand result
  logic [CntW-1:0] hit_cnt_q, acc_cnt_q;
  logic            hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cnt_q <= '0;
      acc_cnt_q <= '0;
      hit_q     <= 1'b0;
    end else if (cmd_i.upd && !cmd_i.pf) begin
      acc_cnt_q <= sat_inc(acc_cnt_q);
      if (hit_any) hit_cnt_q <= sat_inc(hit_cnt_q);
      hit_q <= hit_any;
    end
  end

  // output register
  logic      out_valid_q;
  salc_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.hit          <= hit_q;
      out_q.hit_total    <= hit_cnt_q;
      out_q.access_total <= acc_cnt_q;
    end
  end

  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

// File: hw/rtl/set_assoc_lru_cache_hit_model.sv
// Usage notes:
// Top level of the tag-only set-associative LRU cache hit model.
// Input channel (in_valid_i/in_ready_o) takes one access item: byte address
// and a store flag. Output channel (out_valid_o/out_ready_i) returns one item
// per access: the demand hit flag and the saturating hit and access counts.
// Configuration channel (cfg_valid_i/cfg_ready_o) writes ways_log2 (index 0)
// or mode (index 1); it is always ready. The user must see that it is only
// written while idle; the block itself does not enforce this. Writing
// ways_log2 drops every line; the counters are kept. Each lookup reads the
// set's row from the set memory, then compares, picks the victim and writes
// the row back; a next-line prefetch adds a second lookup. One item is in
// flight at a time; a new item can be accepted as soon as the previous
// result sits in the output register. Reset clears all lines (per-row valid
// flags), counters, ways_log2 to 1 and mode to 0; no clearing pass is
// needed. A stalled receiver holds the result and the block waits with the
// next result until the output register frees.
`timescale 1ns / 1ps
module set_assoc_lru_cache_hit_model
  import salc_pkg::*;
#(
  parameter int unsigned CacheBytes = DefCacheBytes,
  parameter int unsigned MaxWays    = DefMaxWays
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  salc_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output salc_out_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  salc_cmd_t cmd;
  salc_sts_t sts;

  // config writes land the same cycle they are offered
  assign cfg_ready_o = 1'b1;

  // sequence the demand and prefetch lookups
  salc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // hold the set memory, counters and result register
  salc_dp #(
    .CacheBytes (CacheBytes),
    .MaxWays    (MaxWays)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: hw/rtl/salc_checker.sv
// Port-level checker for the cache hit model, bound to the top level.
`timescale 1ns / 1ps
module salc_checker
  import salc_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input salc_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while one is in flight");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result shown during reset");

endmodule

bind set_assoc_lru_cache_hit_model salc_checker u_salc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// File: test/tb_top.sv
// Testbench for the set-associative LRU cache hit model: directed table, random traffic.
`timescale 1ns / 1ps
module tb_top;
  import salc_pkg::*;

  localparam int unsigned NumLines = DefCacheBytes / LineBytes;
  localparam int unsigned CycleLimit = 400000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  salc_in_t            in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  salc_out_t           out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  set_assoc_lru_cache_hit_model DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Shadow cache: tags, valid flags and LRU ranks per line, plus counters.
  logic [AddrW-1:0] shd_tag   [NumLines];
  logic             shd_valid [NumLines];
  logic [RankW-1:0] shd_rank  [NumLines];
  logic [CntW-1:0]  shd_hits;
  logic [CntW-1:0]  shd_accesses;
  int unsigned      geo_ways;
  int unsigned      geo_sets;
  int unsigned      geo_idx_bits;
  salc_mode_e       cur_mode;

  salc_out_t        pending_results[$];
  int               error_count;
  int               results_seen;
  int               hits_seen;
  longint           cycle_count;

  // Idle phase knobs: percent of cycles the sender idles / the receiver stalls.
  int unsigned      send_idle_pct;
  int unsigned      recv_stall_pct;
  bit               hold_off;

  // Rebuild geometry from a raw ways_log2 write and drop every line.
  function automatic void set_geometry(logic [WlW-1:0] raw);
    int unsigned w;
    int unsigned b;
    w = raw;
    if (w < 1) w = 1;
    if (w > 4) w = 4;
    while (w > 1 && (1 << w) > DefMaxWays) w--;
    geo_ways = 1 << w;
    geo_sets = NumLines >> w;
    b = 0;
    while (b < 26 && (2 << b) <= geo_sets) b++;
    geo_idx_bits = b;
    for (int i = 0; i < NumLines; i++) begin
      shd_valid[i] = 1'b0;
      shd_rank[i]  = '0;
    end
  endfunction

  // Promote one way to most recently used, aging the younger ways.
  function automatic void promote_way(int unsigned base, int unsigned way);
    int unsigned old;
    old = shd_valid[base + way] ? shd_rank[base + way] : geo_ways;
    for (int i = 0; i < geo_ways; i++) begin
      if (i != way && shd_valid[base + i] && shd_rank[base + i] < old)
        shd_rank[base + i] = shd_rank[base + i] + 1'b1;
    end
    shd_rank[base + way] = '0;
  endfunction

  function automatic bit probe_line(logic [AddrW-1:0] addr, bit alloc);
    int unsigned set_idx;
    int unsigned base;
    int unsigned victim;
    logic [AddrW-1:0] tag;
    bit free_found;
    set_idx = ((addr >> OffsetBits) & ((1 << geo_idx_bits) - 1)) % geo_sets;
    tag = addr >> (OffsetBits + geo_idx_bits);
    base = set_idx * geo_ways;
    for (int i = 0; i < geo_ways; i++) begin
      if (shd_valid[base + i] && shd_tag[base + i] == tag) begin
        promote_way(base, i);
        return 1'b1;
      end
    end
    if (!alloc) return 1'b0;
    victim = 0;
    free_found = 1'b0;
    for (int i = 0; i < geo_ways; i++) begin
      if (!free_found && !shd_valid[base + i]) begin
        victim = i;
        free_found = 1'b1;
      end
    end
    if (!free_found) begin
      for (int i = 1; i < geo_ways; i++)
        if (shd_rank[base + i] > shd_rank[base + victim]) victim = i;
    end
    promote_way(base, victim);
    shd_tag[base + victim] = tag;
    shd_valid[base + victim] = 1'b1;
    return 1'b0;
  endfunction

  // Predict the result of one access and advance the shadow state.
  function automatic salc_out_t predict_access(salc_in_t acc);
    salc_out_t r;
    bit hit;
    if (!(&shd_accesses)) shd_accesses++;
    hit = probe_line(acc.address, !(cur_mode == MODE_NO_ST_ALC && acc.is_store));
    if (hit && !(&shd_hits)) shd_hits++;
    if (cur_mode == MODE_PF_ALWAYS || (cur_mode == MODE_PF_MISS && !hit))
      void'(probe_line(acc.address + LineBytes, 1'b1));
    r.hit = hit;
    r.hit_total = shd_hits;
    r.access_total = shd_accesses;
    return r;
  endfunction

  // Clock, cycle counter and timeout.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL set_assoc_lru_cache_hit_model");
      $finish;
    end
  end

  // Receiver: check each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    salc_out_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no access outstanding: %p", out_data_o);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        results_seen++;
        if (out_data_o.hit) hits_seen++;
        if (out_data_o.hit !== exp_r.hit) begin
          $error("hit: expected %0d actual %0d", exp_r.hit, out_data_o.hit);
          error_count++;
        end
        if (out_data_o.hit_total !== exp_r.hit_total) begin
          $error("hit_total: expected %0d actual %0d", exp_r.hit_total,
                 out_data_o.hit_total);
          error_count++;
        end
        if (out_data_o.access_total !== exp_r.access_total) begin
          $error("access_total: expected %0d actual %0d", exp_r.access_total,
                 out_data_o.access_total);
          error_count++;
        end
      end
    end
  end

  // Drive ready at the falling edge; hold it low entirely during a hold-off.
  always @(negedge clk_i) begin
    if (hold_off) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one access and wait for it to be taken; predict on acceptance.
  task automatic send_access(salc_in_t acc);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= acc;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results = {pending_results, predict_access(acc)};
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    // the block is still busy with the accepted item, so this gap costs nothing
    @(negedge clk_i);
  endtask

  // Send an access whose result is known from the table; check the queued prediction against it.
  task automatic send_known(salc_in_t acc, salc_out_t known);
    salc_out_t p;
    send_access(acc);
    p = pending_results[$];
    if (p !== known) begin
      $error("table row disagrees with prediction: %p vs %p", known, p);
      error_count++;
    end
  endtask

  // Let the block go quiet, then write one register.
  task automatic write_reg(salc_reg_e idx, logic [CfgDataW-1:0] val);
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == REG_WAYS_LOG2) set_geometry(val);
    else if (idx == REG_MODE) cur_mode = salc_mode_e'(val[1:0]);
  endtask

  // Random access: mostly a small working set to get hits and evictions.
  function automatic salc_in_t rand_access();
    salc_in_t a;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      // few tags over few sets: conflicts and refills
      a.address = ($urandom_range(23) << 14) | ($urandom_range(3) << 5) | $urandom_range(31);
    end else if (pick < 85) begin
      // near the top of memory, so the next line can wrap
      a.address = 32'hFFFF_FF00 | $urandom_range(255);
    end else begin
      a.address = $urandom;
    end
    a.is_store = 1'($urandom_range(1));
    return a;
  endfunction

  typedef struct {
    salc_in_t  acc;
    bit        known;
    salc_out_t result;
  } access_row_t;

  access_row_t dir_rows[$];

  initial begin
    salc_in_t a;
    logic [CfgDataW-1:0] wl;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_WAYS_LOG2;
    cfg_data_i = '0;
    error_count = 0;
    results_seen = 0;
    hits_seen = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b0;
    cur_mode = MODE_PLAIN;
    shd_hits = '0;
    shd_accesses = '0;
    for (int i = 0; i < NumLines; i++) shd_tag[i] = '0;
    set_geometry(WlW'(1));
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table. Zero address misses after reset despite the cleared tag.
    dir_rows = '{
      '{'{32'h0000_0000, 1'b0}, 1'b1, '{1'b0, 32'd0, 32'd1}},
      '{'{32'h0000_001F, 1'b0}, 1'b1, '{1'b1, 32'd1, 32'd2}},
      '{'{32'hFFFF_FFFF, 1'b1}, 1'b1, '{1'b0, 32'd1, 32'd3}},
      '{'{32'hFFFF_FFE0, 1'b0}, 1'b1, '{1'b1, 32'd2, 32'd4}},
      '{'{32'h0000_2000, 1'b0}, 1'b0, '{1'b0, 32'd0, 32'd0}},
      '{'{32'h0000_4000, 1'b0}, 1'b0, '{1'b0, 32'd0, 32'd0}},
      '{'{32'h0000_0000, 1'b1}, 1'b0, '{1'b0, 32'd0, 32'd0}},
      '{'{32'hAAAA_AAAA, 1'b1}, 1'b0, '{1'b0, 32'd0, 32'd0}},
      '{'{32'h5555_5555, 1'b0}, 1'b0, '{1'b0, 32'd0, 32'd0}}
    };
    foreach (dir_rows[i]) begin
      if (dir_rows[i].known) send_known(dir_rows[i].acc, dir_rows[i].result);
      else send_access(dir_rows[i].acc);
    end
    // Every mode once, including a store miss without allocation and wrap prefetch.
    for (int m = 0; m < 4; m++) begin
      write_reg(REG_MODE, CfgDataW'(m));
      send_access('{32'h0001_0040 + (m << 16), 1'b1});
      send_access('{32'h0001_0040 + (m << 16), 1'b0});
      send_access('{32'h0001_0060 + (m << 16), 1'b0});
      send_access('{32'hFFFF_FFE0, 1'b0});
    end
    // Out-of-range associativity: zero and seven clamp.
    write_reg(REG_WAYS_LOG2, WlW'(0));
    send_access('{32'h0000_0000, 1'b0});
    write_reg(REG_WAYS_LOG2, WlW'(7));
    send_access('{32'h0000_0000, 1'b0});

    // Random phases over idle patterns, geometries and modes.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      wl = (ph == 0) ? WlW'(1) : (ph == 1) ? WlW'(4) : WlW'($urandom_range(7));
      write_reg(REG_WAYS_LOG2, wl);
      write_reg(REG_MODE, CfgDataW'($urandom_range(3)));
      if (ph == 5) begin
        // Long receiver hold-off while the sender keeps offering items.
        fork
          begin
            hold_off = 1'b1;
            repeat (60) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 90; n++) begin
        a = rand_access();
        send_access(a);
      end
    end

    // Drain, then a short quiet tail.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    $display("Covered %0d results (%0d hits) across all modes and 2..16 ways,",
             results_seen, hits_seen);
    $display("with sender gaps, receiver stalls and a long output hold-off.");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("PASS set_assoc_lru_cache_hit_model");
    end else begin
      $display("FAIL set_assoc_lru_cache_hit_model");
    end
    $finish;
  end

endmodule

// File: set_assoc_lru_cache_hit_model.f
hw/rtl/salc_pkg.sv
hw/rtl/salc_ctrl.sv
hw/rtl/salc_dp.sv
hw/rtl/set_assoc_lru_cache_hit_model.sv
hw/rtl/salc_checker.sv
test/tb_top.sv
